FILE: sv/bvtm_pkg.sv
// Shared types and constants of the box variance threshold map.
package bvtm_pkg;

    // Field widths of the stream items
    localparam int PIX_W      = 8;
    localparam int ORG_W      = 10;
    localparam int VAR_W      = 30;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 56;
    localparam int S_TUSER_W  = 2;
    localparam int M_TUSER_W  = 2;
    localparam int M_PAD_W    = M_TDATA_W - 2 * ORG_W - VAR_W;

    // Sum widths: wide enough that the variance stays exact modulo 2^VAR_W
    localparam int SUM_W      = VAR_W - 1;
    localparam int SQ_W       = VAR_W;

    // Configuration port
    localparam int DIM_W      = 11;
    localparam int THR_W      = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LIMIT    = 2'd3;

    localparam logic [DIM_W-1:0] RST_LINE_WIDTH   = 11'd640;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [THR_W-1:0] RST_THRESHOLD    = 14'd30;
    localparam logic [DIM_W-1:0] RST_ROW_LIMIT    = 11'd160;

    // Output queue
    localparam int OUT_DEPTH  = 8;
    localparam int OUT_PTR_W  = 3;
    localparam int OUT_CNT_W  = 4;

    // One column entry: pixel sum and square sum of the last rows
    typedef struct packed {
        logic [SQ_W-1:0]  sq;
        logic [SUM_W-1:0] sum;
    } t_col;

    // Per-pixel control carried from the column stage to the window stage
    typedef struct packed {
        logic             win;
        logic             mask;
        logic             first;
        logic             sub;
        logic             row_ok;
        logic [ORG_W-1:0] ox;
        logic [ORG_W-1:0] oy;
    } t_win_ctl;

    // One result item
    typedef struct packed {
        logic             window_valid;
        logic             above_threshold;
        logic [ORG_W-1:0] origin_x;
        logic [ORG_W-1:0] origin_y;
        logic [VAR_W-1:0] scaled_variance;
    } t_result;

endpackage

FILE: sv/bvtm_front.sv
// Raster position tracking, line store and column sum memory with read-modify-write.
module bvtm_front #(
    parameter int WINDOW     = 16,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [bvtm_pkg::PIX_W-1:0]     i_pixel,
    input  logic                           i_mask,
    input  logic                           i_frame_start,
    input  logic [bvtm_pkg::DIM_W-1:0]     i_line_width,
    input  logic [bvtm_pkg::DIM_W-1:0]     i_frame_height,
    input  logic [bvtm_pkg::DIM_W-1:0]     i_row_limit,
    output logic                           o_valid,
    output bvtm_pkg::t_win_ctl             o_ctl,
    output bvtm_pkg::t_col                 o_col
);
    import bvtm_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CW1  = CW + 1;
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int RMW  = $clog2(WINDOW);
    localparam int MXW  = (CW > RW) ? CW : RW;
    localparam int LX   = ((MXW > DIM_W) ? MXW : DIM_W) + 2;
    localparam int LSD  = WINDOW << CW;
    localparam int PSQ_W = 2 * PIX_W;

    // Position state
    logic [CW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic [RMW-1:0] r_rmod;
    logic [CW:0]    r_fill;

    logic [CW-1:0]  c0;
    logic [RW-1:0]  r0;
    logic [RMW-1:0] rm0;
    logic [CW:0]    fill0;
    logic [CW:0]    fill_nx;
    logic [CW:0]    c0_inc;
    logic [LX-1:0]  cx, rx, lwx, fhx, wx, hx, ox_x, oy_x;
    logic           col_end, row_end, win, row_ok, col_hit, old_hit, fwd_hit;
    logic [RMW+CW-1:0] ls_addr;
    t_win_ctl       ctl0;

    // Memories
    logic [PIX_W-1:0] r_ls_mem [0:LSD-1];
    logic [PIX_W-1:0] r_ls_q;
    t_col             r_cm_mem [0:MAX_WIDTH-1];
    t_col             r_cm_q;

    // Stage one
    logic             r1_v;
    logic [CW-1:0]    r1_c;
    logic [PIX_W-1:0] r1_p;
    logic             r1_oldv;
    logic             r1_colv;
    logic             r1_fwd;
    t_col             r1_fwd_col;
    t_win_ctl         r1_ctl;

    logic [PIX_W-1:0] old_pix;
    logic [PSQ_W-1:0] p_sq, o_sq;
    t_col             base, n_col;

    // Resolve position, geometry and window flags of the incoming pixel
    always_comb begin
        c0    = i_frame_start ? '0 : r_col;
        r0    = i_frame_start ? '0 : r_row;
        rm0   = i_frame_start ? '0 : r_rmod;
        fill0 = i_frame_start ? '0 : r_fill;
        cx    = LX'(c0);
        rx    = LX'(r0);
        lwx   = LX'(i_line_width);
        fhx   = LX'(i_frame_height);
        wx    = (lwx == '0) ? LX'(1) : ((lwx > LX'(MAX_WIDTH)) ? LX'(MAX_WIDTH) : lwx);
        hx    = (fhx == '0) ? LX'(1) : ((fhx > LX'(MAX_HEIGHT)) ? LX'(MAX_HEIGHT) : fhx);
        col_end = (cx + LX'(1)) >= wx;
        row_end = (rx + LX'(1)) >= hx;
        win     = ((cx + LX'(1)) >= LX'(WINDOW)) && ((rx + LX'(1)) >= LX'(WINDOW))
                  && (cx < wx) && (rx < hx);
        ox_x    = cx + LX'(1) - LX'(WINDOW);
        oy_x    = rx + LX'(1) - LX'(WINDOW);
        row_ok  = (rx + LX'(1)) < (LX'(i_row_limit) + LX'(WINDOW));
        c0_inc  = CW1'(c0) + CW1'(1);
        fill_nx = (c0_inc > fill0) ? c0_inc : fill0;
        // Column entries at or past the fill count are still cleared for this frame
        col_hit = CW1'(c0) < fill0;
        old_hit = rx >= LX'(WINDOW);
        fwd_hit = r1_v && (r1_c == c0);
        ls_addr = {rm0, c0};

        ctl0.win    = win;
        ctl0.mask   = i_mask;
        ctl0.first  = (c0 == '0);
        ctl0.sub    = cx >= LX'(WINDOW);
        ctl0.row_ok = row_ok;
        ctl0.ox     = ox_x[ORG_W-1:0];
        ctl0.oy     = oy_x[ORG_W-1:0];
    end

    // Advance raster position on each accepted pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_rmod <= '0;
            r_fill <= '0;
        end else if (i_valid) begin
            if (col_end) begin
                r_col <= '0;
                if (row_end) begin
                    r_row  <= '0;
                    r_rmod <= '0;
                    r_fill <= '0;
                end else begin
                    r_row  <= r0 + RW'(1);
                    r_rmod <= (rm0 == RMW'(WINDOW - 1)) ? '0 : rm0 + RMW'(1);
                    r_fill <= fill_nx;
                end
            end else begin
                r_col  <= c0 + CW'(1);
                r_row  <= r0;
                r_rmod <= rm0;
                r_fill <= fill_nx;
            end
        end
    end

    // Line store: read the oldest pixel of the slot, then overwrite it
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_ls_q            <= r_ls_mem[ls_addr];
            r_ls_mem[ls_addr] <= i_pixel;
        end
    end

    // Column memory: read at accept, write back the update in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_cm_q <= r_cm_mem[c0];
        end
        if (r1_v) begin
            r_cm_mem[r1_c] <= n_col;
        end
    end

    // Stage one control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
        end
    end

    // Stage one payload; catch the update in flight to the same column
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r1_c       <= c0;
            r1_p       <= i_pixel;
            r1_oldv    <= old_hit;
            r1_colv    <= col_hit;
            r1_fwd     <= fwd_hit;
            r1_fwd_col <= n_col;
            r1_ctl     <= ctl0;
        end
    end

    // Update the column sums: add the new pixel, drop the one leaving the window
    always_comb begin
        old_pix   = r1_oldv ? r_ls_q : '0;
        base      = (!r1_colv) ? '0 : (r1_fwd ? r1_fwd_col : r_cm_q);
        p_sq      = PSQ_W'(r1_p) * PSQ_W'(r1_p);
        o_sq      = PSQ_W'(old_pix) * PSQ_W'(old_pix);
        n_col.sum = base.sum + SUM_W'(r1_p) - SUM_W'(old_pix);
        n_col.sq  = base.sq + SQ_W'(p_sq) - SQ_W'(o_sq);
    end

    // Output register toward the window stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r1_v) begin
            o_col <= n_col;
            o_ctl <= r1_ctl;
        end
    end

endmodule

FILE: sv/bvtm_window.sv
// Sliding window sums over the column stream, scaled variance and threshold flag.
module bvtm_window #(
    parameter int WINDOW = 16,
    parameter int TSW    = 31
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  bvtm_pkg::t_win_ctl i_ctl,
    input  bvtm_pkg::t_col     i_col,
    input  logic [TSW-1:0]     i_thr,
    output logic               o_valid,
    output bvtm_pkg::t_result  o_res
);
    import bvtm_pkg::*;

    localparam int N    = WINDOW * WINDOW;
    localparam int NW   = $clog2(N + 1);
    localparam int SSW  = 2 * SUM_W;
    localparam int NQW  = SQ_W + NW;
    localparam int CMPW = (TSW > VAR_W) ? TSW : VAR_W;

    // Window accumulators and the row of the last WINDOW column updates
    logic [SUM_W-1:0] r_ws;
    logic [SQ_W-1:0]  r_wq;
    t_col             r_dl [0:WINDOW-1];
    t_col             sub_col;
    logic [SUM_W-1:0] ws_n;
    logic [SQ_W-1:0]  wq_n;

    logic             r3_v;
    t_win_ctl         r3_ctl;
    logic [SUM_W-1:0] r3_s;
    logic [SQ_W-1:0]  r3_q;
    logic [SSW-1:0]   ss_full;
    logic [NQW-1:0]   nq_full;

    logic             r4_v;
    t_win_ctl         r4_ctl;
    logic [VAR_W-1:0] r4_ss;
    logic [VAR_W-1:0] r4_nq;
    logic [VAR_W-1:0] var_raw, var_m;
    t_result          res;

    // Slide the window: restart at column zero, else add new and drop oldest column
    always_comb begin
        sub_col = i_ctl.sub ? r_dl[WINDOW-1] : '0;
        ws_n    = i_ctl.first ? i_col.sum : r_ws + i_col.sum - sub_col.sum;
        wq_n    = i_ctl.first ? i_col.sq  : r_wq + i_col.sq  - sub_col.sq;
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_ws    <= ws_n;
            r_wq    <= wq_n;
            r_dl[0] <= i_col;
            for (int k = 1; k < WINDOW; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
            r3_ctl  <= i_ctl;
            r3_s    <= ws_n;
            r3_q    <= wq_n;
        end
    end

    // Square of the sum and area times the square sum
    always_comb begin
        ss_full = SSW'(r3_s) * SSW'(r3_s);
        nq_full = NQW'(r3_q) * NQW'(N);
    end

    always_ff @(posedge i_clk) begin
        if (r3_v) begin
            r4_ctl <= r3_ctl;
            r4_ss  <= ss_full[VAR_W-1:0];
            r4_nq  <= nq_full[VAR_W-1:0];
        end
    end

    // Form the variance, apply mask and compare against the scaled threshold
    always_comb begin
        var_raw = r4_nq - r4_ss;
        var_m   = r4_ctl.mask ? var_raw : '0;
        res     = '0;
        if (r4_ctl.win) begin
            res.window_valid    = 1'b1;
            res.origin_x        = r4_ctl.ox;
            res.origin_y        = r4_ctl.oy;
            res.scaled_variance = var_m;
            res.above_threshold = r4_ctl.row_ok && (CMPW'(var_m) > CMPW'(i_thr));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r4_v) begin
            o_res <= res;
        end
    end

    // Stage valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r3_v    <= i_valid;
            r4_v    <= r3_v;
            o_valid <= r4_v;
        end
    end

endmodule

FILE: sv/bvtm_out_fifo.sv
// Small result queue that decouples the pipeline from output backpressure.
module bvtm_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bvtm_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output bvtm_pkg::t_result o_data
);
    import bvtm_pkg::*;

    t_result              r_mem [0:OUT_DEPTH-1];
    logic [OUT_PTR_W-1:0] r_wp;
    logic [OUT_PTR_W-1:0] r_rp;
    logic [OUT_CNT_W-1:0] r_cnt;
    logic                 pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign pop     = i_pop && o_valid;

    // Store pushed results
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + OUT_PTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + OUT_PTR_W'(1);
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + OUT_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - OUT_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: sv/box_variance_threshold_map.sv
// Top level of the box variance threshold map: config registers, pipeline and output queue.
//
//  Channel   | Direction | Payload
//  ----------+-----------+-----------------------------------------------------------
//  s_axis    | in        | tdata: pixel; tuser: mask_bit, frame_start
//  m_axis    | out       | tdata: origin_x, origin_y, scaled_variance; tuser: flags
//  cfg       | in        | index 0 line_width, 1 frame_height, 2 threshold, 3 row_limit
//
//  One pixel in and one result out per cycle, sustained while the output is taken; a result
//  passes the front and window stage registers and the output queue. The column memory is
//  read at accept and written back in the next cycle, with forwarding when the same column
//  follows directly. Reset is synchronous; no clearing pass is needed, column entries past
//  the fill count of the current frame read as zero.
//  Input ready follows a credit count of results in flight and queued (eight deep).
module box_variance_threshold_map #(
    parameter int WINDOW     = 16,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [bvtm_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,  // [7:0] pixel
    input  logic [bvtm_pkg::S_TUSER_W-1:0]      i_s_axis_tuser,  // [0] mask_bit, [1] frame_start
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [9:0] origin_x, [19:10] origin_y, [49:20] scaled_variance, [55:50] zero
    output logic [bvtm_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    // [0] window_valid, [1] above_threshold
    output logic [bvtm_pkg::M_TUSER_W-1:0]      o_m_axis_tuser,
    input  logic                                i_cfg_we,
    input  logic [bvtm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bvtm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bvtm_pkg::*;

    localparam int NN    = WINDOW * WINDOW * WINDOW * WINDOW;
    localparam int TSW   = THR_W + $clog2(NN + 1);
    localparam int OCC_W = $clog2(OUT_DEPTH + 1);

    logic [DIM_W-1:0] r_line_width;
    logic [DIM_W-1:0] r_frame_height;
    logic [THR_W-1:0] r_threshold;
    logic [DIM_W-1:0] r_row_limit;
    logic [TSW-1:0]   r_thr_sc;
    logic [OCC_W-1:0] r_occ;

    logic     acc, dlv;
    logic     f_valid, w_valid;
    t_win_ctl f_ctl;
    t_col     f_col;
    t_result  w_res, q_res;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= RST_LINE_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_threshold    <= RST_THRESHOLD;
            r_row_limit    <= RST_ROW_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LINE_WIDTH:   r_line_width   <= i_cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[DIM_W-1:0];
                REG_THRESHOLD:    r_threshold    <= i_cfg_data[THR_W-1:0];
                REG_ROW_LIMIT:    r_row_limit    <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Threshold scaled by the squared window area
    always_ff @(posedge i_clk) begin
        r_thr_sc <= TSW'(r_threshold) * TSW'(NN);
    end

    // Credit count: results accepted and not yet delivered
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;
    assign dlv             = o_m_axis_tvalid && i_m_axis_tready;
    assign o_s_axis_tready = (r_occ < OCC_W'(OUT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            case ({acc, dlv})
                2'b10:   r_occ <= r_occ + OCC_W'(1);
                2'b01:   r_occ <= r_occ - OCC_W'(1);
                default: r_occ <= r_occ;
            endcase
        end
    end

    bvtm_front #(
        .WINDOW     (WINDOW),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (acc),
        .i_pixel        (i_s_axis_tdata[PIX_W-1:0]),
        .i_mask         (i_s_axis_tuser[0]),
        .i_frame_start  (i_s_axis_tuser[1]),
        .i_line_width   (r_line_width),
        .i_frame_height (r_frame_height),
        .i_row_limit    (r_row_limit),
        .o_valid        (f_valid),
        .o_ctl          (f_ctl),
        .o_col          (f_col)
    );

    bvtm_window #(
        .WINDOW (WINDOW),
        .TSW    (TSW)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_ctl   (f_ctl),
        .i_col   (f_col),
        .i_thr   (r_thr_sc),
        .o_valid (w_valid),
        .o_res   (w_res)
    );

    bvtm_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_valid),
        .i_data  (w_res),
        .i_pop   (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (q_res)
    );

    // Pack the result item
    assign o_m_axis_tdata = {{M_PAD_W{1'b0}}, q_res.scaled_variance,
                             q_res.origin_y, q_res.origin_x};
    assign o_m_axis_tuser = {q_res.above_threshold, q_res.window_valid};

    // A queued result is always covered by a credit
    a_occ_covers_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_occ != '0))
        else $error("result presented with no credit outstanding");

    // The detection flag only comes with a completed window
    a_flag_needs_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> o_m_axis_tuser[0])
        else $error("above_threshold without window_valid");

    // A result without a window carries all-zero data
    a_empty_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("non-window result carries data");

    // A pixel transfer without a result transfer raises the credit count by one
    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !dlv) |=> (r_occ == $past(r_occ) + OCC_W'(1)))
        else $error("credit count out of step");

endmodule
